[src/mrdr_pkg.sv]
// Shared types and constants of the mixed-radix digit-reversal permute block.
`default_nettype none

package mrdr_pkg;

  localparam int unsigned MaxPoints  = 4096;
  localparam int unsigned MaxFactors = 8;
  localparam int unsigned AddrW      = $clog2(MaxPoints);
  localparam int unsigned CntW       = 13;
  localparam int unsigned FactorCntW = 4;
  localparam int unsigned DigitW     = 8;
  localparam int unsigned RemainW    = 16;
  localparam int unsigned DigitIdxW  = $clog2(MaxFactors);
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned WordW      = 32;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegPointCount   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFactorCount  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegFactorsPack  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRemainsLow   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRemainsHigh  = 3'd4;

  // Command codes
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdRead  = 1'b1;

  typedef struct packed {
    logic             command;
    logic [WordW-1:0] sample_re;
    logic [WordW-1:0] sample_im;
  } in_t;

  typedef struct packed {
    logic [WordW-1:0] out_re;
    logic [WordW-1:0] out_im;
    logic             last;
    logic             error;
  } out_t;

endpackage

`default_nettype wire

[src/mrdr_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
`default_nettype none

module mrdr_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[src/mixed_radix_digit_reverse_permute.sv]
// Top level of the mixed-radix digit-reversal permute block.
//
// Usage: a transaction is accepted at a rising edge with start_i high and
// busy_o low. A write command (command = 0) stores the sample at the next
// frame address and gives no result; writes to a full frame are dropped. A
// read command (command = 1) raises busy_o for one cycle; in that cycle
// done_o pulses with the result, so the block takes no new transaction
// while a read's result is out. The limit is the frame RAM's registered read.
// A read before the frame is full returns error with zero data. The read that
// returns the final word marks last and clears the counters for the next frame.
// The receiver cannot stall: each result is on result_o for exactly the one
// cycle that done_o is high.
// Configuration: cfg_we_i writes cfg_data_i to the register cfg_idx_i at once;
// write it only while the block is idle.
// Reset clears counters and restores register defaults (point count 4096, one
// factor); frame RAM content stays undefined until written.
`default_nettype none

module mixed_radix_digit_reverse_permute
  import mrdr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire in_t                 item_i,
  output logic                     done_o,
  output out_t                     result_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers
  logic [CntW-1:0]       point_count_q;
  logic [FactorCntW-1:0] factor_count_q;
  logic [CfgDataW-1:0]   factors_q;
  logic [CfgDataW-1:0]   remains_low_q;
  logic [CfgDataW-1:0]   remains_high_q;

  // Frame counters
  logic [CntW-1:0]   loaded_q, loaded_d;
  logic [CntW-1:0]   emitted_q, emitted_d;
  logic [AddrW-1:0]  src_idx_q, src_idx_d;
  logic [DigitW-1:0] digit_q [MaxFactors];
  logic [DigitW-1:0] digit_d [MaxFactors];

  // Result control
  logic pend_q;
  logic err_q;
  logic last_q;

  logic                  accept;
  logic                  is_read;
  logic                  full;
  logic                  final_word;
  logic [CntW-1:0]       eff_points;
  logic [FactorCntW-1:0] eff_factors;
  logic [AddrW-1:0]      rem [MaxFactors+1];
  logic [DigitW-1:0]     digit_inc [MaxFactors];
  logic [DigitIdxW-1:0]  carry_len;
  logic                  carry_run;
  logic [AddrW-1:0]      rd_addr;
  logic                  ram_we;
  logic                  ram_re;
  logic [2*WordW-1:0]    ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q  <= CntW'(MaxPoints);
      factor_count_q <= FactorCntW'(1);
      factors_q      <= '0;
      remains_low_q  <= '0;
      remains_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegPointCount:  point_count_q  <= cfg_data_i[CntW-1:0];
        RegFactorCount: factor_count_q <= cfg_data_i[FactorCntW-1:0];
        RegFactorsPack: factors_q      <= cfg_data_i;
        RegRemainsLow:  remains_low_q  <= cfg_data_i;
        RegRemainsHigh: remains_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Saturate the configured counts into their legal ranges
  always_comb begin
    if (point_count_q < CntW'(2)) begin
      eff_points = CntW'(2);
    end else if (point_count_q > CntW'(MaxPoints)) begin
      eff_points = CntW'(MaxPoints);
    end else begin
      eff_points = point_count_q;
    end
    if (factor_count_q < FactorCntW'(1)) begin
      eff_factors = FactorCntW'(1);
    end else if (factor_count_q > FactorCntW'(MaxFactors)) begin
      eff_factors = FactorCntW'(MaxFactors);
    end else begin
      eff_factors = factor_count_q;
    end
  end

  // Remainders, kept modulo MaxPoints since only the address bits matter
  always_comb begin
    rem[0] = eff_points[AddrW-1:0];
    for (int j = 0; j < 4; j++) begin
      rem[j+1] = remains_low_q[j*RemainW +: AddrW];
      rem[j+5] = remains_high_q[j*RemainW +: AddrW];
    end
  end

  // Digit counter: count how many low digits carry, the top digit in use
  // never carries and wraps instead.
  always_comb begin
    carry_run = 1'b1;
    carry_len = '0;
    for (int j = 0; j < MaxFactors; j++) begin
      digit_inc[j] = digit_q[j] + DigitW'(1);
    end
    for (int j = 1; j < MaxFactors; j++) begin
      if (carry_run && (FactorCntW'(j) < eff_factors)
          && (digit_inc[j-1] >= factors_q[(j-1)*DigitW +: DigitW])) begin
        carry_len = DigitIdxW'(j);
      end else begin
        carry_run = 1'b0;
      end
    end
  end

  assign accept     = start_i && !busy_o;
  assign is_read    = (item_i.command == CmdRead);
  assign full       = (loaded_q >= eff_points);
  assign final_word = (emitted_q >= (eff_points - CntW'(1)));
  assign rd_addr    = final_word ? AddrW'(eff_points - CntW'(1)) : src_idx_q;
  assign ram_we     = accept && !is_read && !full;
  assign ram_re     = accept && is_read && full;

  always_comb begin
    loaded_d  = loaded_q;
    emitted_d = emitted_q;
    src_idx_d = src_idx_q;
    for (int j = 0; j < MaxFactors; j++) begin
      digit_d[j] = digit_q[j];
    end
    if (ram_we) begin
      loaded_d = loaded_q + CntW'(1);
    end else if (ram_re) begin
      if (final_word) begin
        // Frame done: clear for the next one
        loaded_d  = '0;
        emitted_d = '0;
        src_idx_d = '0;
        for (int j = 0; j < MaxFactors; j++) begin
          digit_d[j] = '0;
        end
      end else begin
        emitted_d = emitted_q + CntW'(1);
        // Net index step of carry_len carries telescopes to r[k] + r[k+1] - r[0]
        src_idx_d = src_idx_q + rem[{1'b0, carry_len}]
                    + rem[{1'b0, carry_len} + (DigitIdxW+1)'(1)] - rem[0];
        for (int j = 0; j < MaxFactors; j++) begin
          if (DigitIdxW'(j) < carry_len) begin
            digit_d[j] = '0;
          end else if (DigitIdxW'(j) == carry_len) begin
            digit_d[j] = digit_inc[j];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q  <= '0;
      emitted_q <= '0;
      src_idx_q <= '0;
      for (int j = 0; j < MaxFactors; j++) begin
        digit_q[j] <= '0;
      end
      pend_q <= 1'b0;
      err_q  <= 1'b0;
      last_q <= 1'b0;
    end else begin
      loaded_q  <= loaded_d;
      emitted_q <= emitted_d;
      src_idx_q <= src_idx_d;
      for (int j = 0; j < MaxFactors; j++) begin
        digit_q[j] <= digit_d[j];
      end
      pend_q <= accept && is_read;
      err_q  <= accept && is_read && !full;
      last_q <= ram_re && final_word;
    end
  end

  mrdr_ram #(
    .Width (2 * WordW),
    .Depth (MaxPoints)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (loaded_q[AddrW-1:0]),
    .wdata_i ({item_i.sample_re, item_i.sample_im}),
    .re_i    (ram_re),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  assign busy_o          = pend_q;
  assign done_o          = pend_q;
  assign result_o.out_re = err_q ? '0 : ram_rdata[2*WordW-1:WordW];
  assign result_o.out_im = err_q ? '0 : ram_rdata[WordW-1:0];
  assign result_o.last   = last_q;
  assign result_o.error  = err_q;

endmodule

`default_nettype wire

[test/mrdr_permute_checker.sv]
// Checker for the permute block: watches both channels, predicts each result and compares.
module mrdr_permute_checker
  import mrdr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  in_t                 item_i,
  input  logic                done_i,
  input  out_t                result_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  checked_o
);

  logic [WordW-1:0]      frame_re_q [MaxPoints];
  logic [WordW-1:0]      frame_im_q [MaxPoints];
  logic [CntW-1:0]       points_r;
  logic [FactorCntW-1:0] nfac_r;
  logic [CfgDataW-1:0]   factors_r;
  logic [CfgDataW-1:0]   rem_lo_r;
  logic [CfgDataW-1:0]   rem_hi_r;
  int unsigned           loaded_n;
  int unsigned           emitted_n;
  logic [31:0]           src_idx;
  logic [DigitW-1:0]     digits [MaxFactors];
  out_t                  permuted_q [$];
  int                    errs;
  int                    checked;

  function automatic int unsigned points_now();
    if (points_r < 2) return 2;
    if (points_r > MaxPoints) return MaxPoints;
    return points_r;
  endfunction

  // factor j, j = 1..8
  function automatic int unsigned factor_at(int unsigned j);
    return factors_r[8*((j-1)%8) +: 8];
  endfunction

  // remainder j, j = 0..8; remainder zero is the point count
  function automatic int unsigned remain_at(int unsigned j);
    if (j == 0) return points_now();
    if (j <= 4) return rem_lo_r[16*(j-1) +: 16];
    return rem_hi_r[16*(j-5) +: 16];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : predict_and_compare
    int unsigned n;
    int unsigned nf;
    int unsigned j;
    out_t want;
    if (!rst_ni) begin
      points_r  = 13'd4096;
      nfac_r    = 4'd1;
      factors_r = '0;
      rem_lo_r  = '0;
      rem_hi_r  = '0;
      loaded_n  = 0;
      emitted_n = 0;
      src_idx   = '0;
      foreach (digits[i]) digits[i] = '0;
      permuted_q.delete();
      errs    = 0;
      checked = 0;
    end else begin
      if (cfg_we_i === 1'b1) begin
        case (cfg_idx_i)
          RegPointCount:  points_r  = cfg_data_i[CntW-1:0];
          RegFactorCount: nfac_r    = cfg_data_i[FactorCntW-1:0];
          RegFactorsPack: factors_r = cfg_data_i;
          RegRemainsLow:  rem_lo_r  = cfg_data_i;
          RegRemainsHigh: rem_hi_r  = cfg_data_i;
          default: ;
        endcase
      end

      if (done_i === 1'b1) begin
        checked++;
        if (permuted_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("unexpected result: re=%h im=%h last=%b error=%b",
                     result_i.out_re, result_i.out_im, result_i.last, result_i.error);
        end else begin
          want = permuted_q.pop_front();
          if (result_i.out_re !== want.out_re || result_i.out_im !== want.out_im ||
              result_i.last !== want.last || result_i.error !== want.error) begin
            errs++;
            if (errs <= 10)
              $display("mismatch: expected re=%h im=%h last=%b error=%b, %s",
                       want.out_re, want.out_im, want.last, want.error,
                       $sformatf("got re=%h im=%h last=%b error=%b",
                                 result_i.out_re, result_i.out_im,
                                 result_i.last, result_i.error));
          end
        end
      end

      if (start_i === 1'b1 && busy_i === 1'b0) begin
        n = points_now();
        if (item_i.command == CmdWrite) begin
          // drop writes into a full frame
          if (loaded_n < n) begin
            frame_re_q[loaded_n] = item_i.sample_re;
            frame_im_q[loaded_n] = item_i.sample_im;
            loaded_n++;
          end
        end else begin
          want = '0;
          if (loaded_n < n) begin
            want.error = 1'b1;
          end else if (emitted_n >= n - 1) begin
            // final word comes from the last address, then clear for the next frame
            want.out_re = frame_re_q[n-1];
            want.out_im = frame_im_q[n-1];
            want.last   = 1'b1;
            loaded_n  = 0;
            emitted_n = 0;
            src_idx   = '0;
            foreach (digits[i]) digits[i] = '0;
          end else begin
            want.out_re = frame_re_q[src_idx % MaxPoints];
            want.out_im = frame_im_q[src_idx % MaxPoints];
            emitted_n++;
            // advance the digit counter; the top digit never carries
            nf = (nfac_r < 1) ? 1 : ((nfac_r > MaxFactors) ? MaxFactors : nfac_r);
            j = 1;
            src_idx = src_idx + remain_at(1);
            digits[0] = digits[0] + 1'b1;
            while (j < nf && digits[j-1] >= factor_at(j)) begin
              digits[j-1] = '0;
              src_idx = src_idx - remain_at(j-1) + remain_at(j+1);
              j++;
              digits[j-1] = digits[j-1] + 1'b1;
            end
          end
          permuted_q.push_back(want);
        end
      end
    end
    fail_count_o <= errs;
    pending_o    <= permuted_q.size();
    checked_o    <= checked;
  end

endmodule

[test/tb_mixed_radix_digit_reverse_permute.sv]
// Testbench top for the mixed-radix digit-reversal permute block: stimulus and verdict.
module tb_mixed_radix_digit_reverse_permute;
  import mrdr_pkg::*;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                start_i    = 1'b0;
  in_t                 item_i     = '0;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = RegPointCount;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                busy_o;
  logic                done_o;
  out_t                result_o;

  int          fail_count;
  int          pending;
  int          checked;
  int unsigned idle_pct   = 19;
  int unsigned items_sent = 0;
  int unsigned frames_run = 0;

  always #2 clk_i = ~clk_i;

  mixed_radix_digit_reverse_permute u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  mrdr_permute_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .item_i       (item_i),
    .done_i       (done_o),
    .result_i     (result_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  function automatic in_t write_cmd(input logic [WordW-1:0] re, input logic [WordW-1:0] im);
    in_t it;
    it.command   = CmdWrite;
    it.sample_re = re;
    it.sample_im = im;
    return it;
  endfunction

  function automatic in_t read_cmd();
    in_t it;
    it.command   = CmdRead;
    it.sample_re = $urandom;
    it.sample_im = $urandom;
    return it;
  endfunction

  // Hand one transaction to the block; start stays high into the next call.
  task automatic issue(input in_t it);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      item_i  <= in_t'({$urandom, $urandom, $urandom});
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Drop start and wait until every predicted result has come back.
  task automatic settle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [CfgDataW-1:0] pc, fc, fp, rl, rh);
    logic [CfgDataW-1:0] vals [5];
    logic [CfgIdxW-1:0]  regs [5];
    vals = '{pc, fc, fp, rl, rh};
    regs = '{RegPointCount, RegFactorCount, RegFactorsPack, RegRemainsLow, RegRemainsHigh};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= regs[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // One frame: new settings, loading with stray early reads, then the permuted reads.
  task automatic random_frame();
    logic [CfgDataW-1:0] pc, fc, fp, rl, rh;
    int unsigned k, prod, run, f, fmax, cap, n_plan, rd;
    int unsigned fe [MaxFactors];
    pc = {$urandom, $urandom};
    fc = {$urandom, $urandom};
    fp = {$urandom, $urandom};
    rl = {$urandom, $urandom};
    rh = {$urandom, $urandom};
    if ($urandom_range(7) == 0) begin
      // loose settings: saturated counts, arbitrary factors and remainders; a frame
      // of at most two points only ever reads addresses zero and one
      pc[CntW-1:0] = $urandom_range(0, 2);
      fc[FactorCntW-1:0] = $urandom_range(0, 15);
      case ($urandom_range(3))
        0: fp = '0;
        1: fp = '1;
        default: ;
      endcase
      if ($urandom_range(3) == 0) rl = '1;
      if ($urandom_range(3) == 0) rh = '0;
    end else begin
      cap  = ($urandom_range(9) == 0) ? 300 : 96;
      fmax = ($urandom_range(5) == 0) ? 16 : 4;
      k    = $urandom_range(1, MaxFactors);
      prod = 1;
      for (int unsigned j = 0; j < k; j++) begin
        f = $urandom_range(2, fmax);
        if (j != 0 && $urandom_range(7) == 0) f = $urandom_range(0, 1);
        if (prod * f > cap) f = 1;
        fe[j] = (f == 0) ? 1 : f;
        prod  = prod * fe[j];
        fp[8*j +: 8] = f;
      end
      // digit weights: point count over the running product of the factors
      run = prod;
      for (int unsigned j = 0; j < k; j++) begin
        run = run / fe[j];
        if (j < 4) rl[16*j +: 16] = run;
        else rh[16*(j-4) +: 16] = run;
      end
      pc[CntW-1:0] = prod;
      fc[FactorCntW-1:0] = k;
    end
    n_plan = pc[CntW-1:0];
    if (n_plan < 2) n_plan = 2;
    if (n_plan > MaxPoints) n_plan = MaxPoints;

    settle();
    program_regs(pc, fc, fp, rl, rh);
    frames_run++;
    if ($urandom_range(3) == 0) issue(read_cmd());
    for (int unsigned i = 0; i < n_plan; i++) begin
      issue(write_cmd($urandom, $urandom));
      if (i + 1 < n_plan && $urandom_range(11) == 0) issue(read_cmd());
    end
    if ($urandom_range(5) == 0) repeat ($urandom_range(1, 2)) issue(write_cmd($urandom, $urandom));
    // now and then stop reading partway, then shrink the frame under the open
    // counters so that the next read returns the final word
    rd = ($urandom_range(9) == 0) ? $urandom_range(1, n_plan) : n_plan;
    repeat (rd) issue(read_cmd());
    if (rd < n_plan) begin
      settle();
      pc[CntW-1:0] = $urandom_range(2, rd + 1);
      program_regs(pc, fc, fp, rl, rh);
      issue(read_cmd());
    end
  endtask

  initial begin : stimulus
    logic [CfgDataW-1:0] rl;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // read on an empty frame at the default size
    issue(read_cmd());

    // one factor over 300 points: the top digit runs past its wrap and the
    // remainder keeps only its low address bits
    settle();
    rl = {$urandom, $urandom};
    rl[15:0] = 16'hF001;
    program_regs(64'hFFFF_FFFF_FFFF_E12C, 64'hFFFF_FFFF_FFFF_FFF1, '1, rl, '1);
    frames_run++;
    issue(write_cmd('0, '0));
    issue(write_cmd('1, '1));
    issue(write_cmd(32'hAAAA_AAAA, 32'h5555_5555));
    issue(write_cmd(32'h5555_5555, 32'hAAAA_AAAA));
    for (int i = 4; i < 300; i++) issue(write_cmd($urandom, $urandom));
    issue(write_cmd($urandom, $urandom));
    repeat (280) issue(read_cmd());

    // shrink the frame mid-way: the next read is the final one
    settle();
    program_regs(64'hFFFF_FFFF_FFFF_E002, 64'h1, '0, '0, '0);
    frames_run++;
    issue(read_cmd());
    issue(read_cmd());

    while (items_sent < 1950) begin
      idle_pct = (items_sent < 650) ? 19 : ((items_sent < 1300) ? 57 : 0);
      random_frame();
    end
    settle();

    $display("Covered %0d transactions over %0d settings, %0d results checked.",
             items_sent, frames_run, checked);
    $display("Frames up to a few hundred points, one to eight factors, early reads,");
    $display("dropped writes and frames shrunk under open counters.");
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[sim.f]
src/mrdr_pkg.sv
src/mrdr_ram.sv
src/mixed_radix_digit_reverse_permute.sv
test/mrdr_permute_checker.sv
test/tb_mixed_radix_digit_reverse_permute.sv
